// ===== sv/awf_pkg.sv =====
// ----------------------------------------------------------------------------
// awf_pkg
// shared types and codes of the advertising whitelist filter
// ----------------------------------------------------------------------------
package awf_pkg;

  localparam logic [2:0] MODE_PAIR   = 3'd0;
  localparam logic [2:0] MODE_UNPAIR = 3'd1;
  localparam logic [2:0] MODE_QUERY  = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_ADV    = 3'd4;

  localparam logic [2:0] KIND_PAIR   = 3'd0;
  localparam logic [2:0] KIND_UNPAIR = 3'd1;
  localparam logic [2:0] KIND_QUERY  = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [7:0] MFR_TYPE    = 8'hFF;
  localparam logic [7:0] NEW_VALUE   = 8'hFF;
  localparam logic [7:0] ALARM_VALUE = 8'hEE;
  localparam logic [7:0] EVT_NONCONN = 8'h03;
  localparam logic [7:0] DEV_ALARM   = 8'h03;
  localparam logic [7:0] DEV_ONE     = 8'h01;
  localparam logic [7:0] DEV_TWO     = 8'h02;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [7:0] value;
  } parse_res_t;

endpackage

// ===== sv/awf_parser.sv =====
// ----------------------------------------------------------------------------
// awf_parser
// walks advertising bytes as length-type structures, one byte per transfer
// ----------------------------------------------------------------------------
module awf_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          report_length,
  input  logic [7:0]          adv_byte,
  output awf_pkg::parse_res_t res
);

  logic [7:0] byte_position;
  logic [7:0] next_structure_at;
  logic [7:0] structure_length;
  logic [7:0] structure_kind;
  logic       parse_stopped;
  logic       value_found;
  logic [7:0] found_value;

  logic [8:0] p1;
  logic [8:0] nsa_len;
  logic       ends;

  assign p1      = {1'b0, byte_position} + 9'd1;
  assign nsa_len = {1'b0, next_structure_at} + {1'b0, adv_byte};
  assign ends    = p1 >= {1'b0, report_length};

  always_comb begin
    res.done  = ends;
    res.found = value_found;
    res.value = found_value;
    if (!parse_stopped && !value_found && byte_position < report_length &&
        byte_position != next_structure_at &&
        {1'b0, byte_position} == {1'b0, next_structure_at} + 9'd4 &&
        structure_kind == awf_pkg::MFR_TYPE && structure_length >= 8'd4) begin
      res.found = 1'b1;
      res.value = adv_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      next_structure_at <= '0;
      structure_length  <= '0;
      structure_kind    <= '0;
      parse_stopped     <= 1'b0;
      value_found       <= 1'b0;
      found_value       <= '0;
    end else if (step) begin
      if (ends) begin
        byte_position     <= '0;
        next_structure_at <= '0;
        structure_length  <= '0;
        structure_kind    <= '0;
        parse_stopped     <= 1'b0;
        value_found       <= 1'b0;
        found_value       <= '0;
      end else begin
        byte_position <= p1[7:0];
        if (!parse_stopped && !value_found && byte_position < report_length) begin
          if (byte_position == next_structure_at) begin
            if (adv_byte == 8'd0 || nsa_len >= {1'b0, report_length}) begin
              parse_stopped <= 1'b1;
            end else begin
              structure_length <= adv_byte;
            end
          end else if (res.found) begin
            value_found <= 1'b1;
            found_value <= adv_byte;
          end else begin
            if ({1'b0, byte_position} == {1'b0, next_structure_at} + 9'd1) begin
              structure_kind <= adv_byte;
            end
            if ({1'b0, byte_position} ==
                {1'b0, next_structure_at} + {1'b0, structure_length}) begin
              next_structure_at <= byte_position + 8'd1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== sv/awf_table.sv =====
// ----------------------------------------------------------------------------
// awf_table
// address table in synchronous memory with a scanning sequencer
// ----------------------------------------------------------------------------
module awf_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op_mode,
  input  logic [47:0] op_mac,
  input  logic [7:0]  op_type,
  input  logic        op_report,
  input  logic [7:0]  op_value,
  output logic        busy,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic        ok,
  output logic [47:0] mac_res,
  output logic [7:0]  value,
  output logic [4:0]  count
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = 64;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_MOVE  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  logic [EW-1:0] mem [MAX_ENTRIES];
  logic [EW-1:0] rdata;
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  state_t        state;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [IW-1:0] hit;
  logic [2:0]    mode;
  logic [47:0]   mac;
  logic [7:0]    dtype;
  logic          report;
  logic [7:0]    v;
  logic          res_ok;

  logic match;
  logic last;
  logic pair_add;
  logic pair_we;
  logic status_alarm;
  logic status_send;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign match    = rdata[63:16] == mac;
  assign last     = idx + CW'(1) >= entry_count;
  assign busy     = state != S_IDLE;
  assign pair_add = mode == awf_pkg::MODE_PAIR && !res_ok &&
                    entry_count < CW'(MAX_ENTRIES);
  assign pair_we  = state == S_DONE && !report && pair_add;

  assign status_alarm = rdata[15:8] == awf_pkg::DEV_ALARM && v != 8'd0;
  assign status_send  = res_ok && rdata[7:0] != v &&
                        (status_alarm || rdata[15:8] == awf_pkg::DEV_ONE ||
                         rdata[15:8] == awf_pkg::DEV_TWO);

  always_comb begin
    raddr = idx[IW-1:0];
    we    = 1'b0;
    waddr = hit;
    wdata = {rdata[63:8], v};
    case (state)
      S_MOVE: raddr = IW'(entry_count);
      S_WRITE: begin
        we = 1'b1;
        if (mode == awf_pkg::MODE_UNPAIR) begin
          wdata = rdata;
        end
      end
      S_DONE: begin
        if (pair_we) begin
          we    = 1'b1;
          waddr = IW'(entry_count);
          wdata = {mac, dtype, awf_pkg::NEW_VALUE};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_IDLE && start && op_mode == awf_pkg::MODE_CLEAR) ||
                (state == S_DONE && (!report || status_send));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            mode   <= op_mode;
            mac    <= op_mac;
            dtype  <= op_type;
            report <= op_report;
            v      <= op_value;
            idx    <= '0;
            if (op_mode == awf_pkg::MODE_CLEAR) begin
              entry_count <= '0;
              kind    <= awf_pkg::KIND_CLEAR;
              ok      <= 1'b1;
              mac_res <= '0;
              value   <= '0;
              count   <= '0;
            end else if (entry_count == '0) begin
              state <= S_DONE;
              res_ok <= 1'b0;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (match) begin
            hit <= idx[IW-1:0];
            res_ok <= 1'b1;
            if (mode == awf_pkg::MODE_UNPAIR) begin
              entry_count <= entry_count - CW'(1);
              state <= S_MOVE;
            end else if (report) begin
              state <= S_WRITE;
            end else begin
              state <= S_DONE;
            end
          end else if (last) begin
            res_ok <= 1'b0;
            state <= S_DONE;
          end else begin
            idx <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_MOVE: state <= S_WRITE;
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          state   <= S_IDLE;
          mac_res <= mac;
          if (report) begin
            kind  <= awf_pkg::KIND_STATUS;
            ok    <= 1'b1;
            count <= 5'(entry_count);
            value <= status_alarm ? awf_pkg::ALARM_VALUE : v;
          end else begin
            kind  <= mode;
            value <= '0;
            if (pair_add) begin
              entry_count <= entry_count + CW'(1);
              count <= 5'(entry_count + CW'(1));
              ok    <= 1'b1;
            end else begin
              count <= 5'(entry_count);
              ok    <= res_ok;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/adv_whitelist_filter.sv =====
// ----------------------------------------------------------------------------
// adv_whitelist_filter
// device address whitelist with advertising payload parser
// ----------------------------------------------------------------------------
// channel | signals                                          | direction
// command | start busy mode mac dev_class evt_code ...       | in
// result  | strobe kind ok mac_res value count               | out
//
// an advertising byte that does not start a table update completes without raising busy, clear too
// other table operations and report updates scan the table entry by entry,
// with an extra write step for a report update and a move and write for an unpair hit,
// each entry read through the synchronous read port of the table memory
// reset empties the table and the parse state; no clearing pass
// results are strobed for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
module adv_whitelist_filter #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [47:0] mac,
  input  logic [7:0]  dev_class,
  input  logic [7:0]  evt_code,
  input  logic [7:0]  report_length,
  input  logic [7:0]  adv_byte,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic        ok,
  output logic [47:0] mac_res,
  output logic [7:0]  value,
  output logic [4:0]  count
);

  awf_pkg::parse_res_t pres;
  logic transfer;
  logic is_adv;
  logic tbl_start;
  logic is_tbl;

  assign transfer = start && !busy;
  assign is_adv   = mode == awf_pkg::MODE_ADV;
  assign is_tbl   = mode == awf_pkg::MODE_PAIR || mode == awf_pkg::MODE_UNPAIR ||
                    mode == awf_pkg::MODE_QUERY || mode == awf_pkg::MODE_CLEAR;
  assign tbl_start = transfer && (is_tbl || (is_adv && pres.done && pres.found &&
                     evt_code == awf_pkg::EVT_NONCONN));

  awf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (transfer && is_adv),
    .report_length (report_length),
    .adv_byte      (adv_byte),
    .res           (pres)
  );

  awf_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
    .clk       (clk),
    .rst       (rst),
    .start     (tbl_start),
    .op_mode   (mode),
    .op_mac    (mac),
    .op_type   (dev_class),
    .op_report (is_adv),
    .op_value  (pres.value),
    .busy      (busy),
    .strobe    (strobe),
    .kind      (kind),
    .ok        (ok),
    .mac_res   (mac_res),
    .value     (value),
    .count     (count)
  );

endmodule
